[hw/rtl/i2cms_pkg.sv]
// Shared types, opcodes and sequence tables for the I2C master byte sequencer.
`default_nettype none

package i2cms_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam logic [PHASE_W-1:0] PHASE_IDLE = 5'd31;
  localparam logic [PHASE_W-1:0] LOOP_BODY  = 5'd2;
  localparam logic [PHASE_W-1:0] STOP_ENTRY = 5'd9;
  localparam logic [PHASE_W-1:0] ACK_TAIL   = 5'd18;
  localparam int unsigned PROG_MAX = 20;

  localparam logic [7:0] TICKS_RESET   = 8'd1;
  localparam logic [7:0] TIMEOUT_RESET = 8'd20;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_ACK      = 3'd4,
    OP_NACK     = 3'd5,
    OP_WAIT_ACK = 3'd6,
    OP_NONE     = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    S_SCL0, S_SCL1, S_SDA0, S_SDA1, S_OUT, S_IN, S_DLY, S_BIT,
    S_SCL1S, S_DLOOP, S_POLL, S_PDLY
  } step_t;

  // Register addresses (byte addresses, word aligned).
  localparam logic [2:0] ADDR_TICKS   = 3'd0;
  localparam logic [2:0] ADDR_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [7:0] ticks_per_us;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [2:0]         active_op;
    logic [2:0]         bit_count;
    logic [7:0]         shift_reg;
    logic [7:0]         delay_count;
    logic [7:0]         poll_count;
    logic               scl_level;
    logic               sda_level;
    logic               sda_enable;
    logic [7:0]         last_read;
    logic               timeout_flag;
  } seq_state_t;

  typedef struct packed {
    logic       ack_missing;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_out;
    logic       scl;
  } result_t;

  localparam seq_state_t STATE_RESET = '{
    phase: PHASE_IDLE, active_op: 3'd0, bit_count: 3'd0, shift_reg: 8'd0,
    delay_count: 8'd0, poll_count: 8'd0, scl_level: 1'b1, sda_level: 1'b1,
    sda_enable: 1'b1, last_read: 8'd0, timeout_flag: 1'b0
  };

  // Pin step programs, one row per opcode except OP_NONE; short rows are padded.
  localparam step_t PROG [7][PROG_MAX] = '{
    '{S_OUT, S_SCL0, S_SDA1, S_SCL1, S_DLY, S_DLY, S_SDA0, S_DLY, S_SCL0,
      S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0,
      S_SCL0, S_SCL0},
    '{S_OUT, S_SCL0, S_SDA0, S_SCL1, S_DLY, S_DLY, S_SDA1, S_DLY, S_SCL0,
      S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0,
      S_SCL0, S_SCL0},
    '{S_OUT, S_SCL0, S_SCL0, S_BIT, S_DLY, S_DLY, S_SCL1, S_DLY, S_DLOOP,
      S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0,
      S_SCL0, S_SCL0},
    '{S_IN, S_SCL0, S_SCL0, S_DLY, S_SCL1S, S_DLOOP, S_SCL0, S_OUT,
      S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0,
      S_SCL0, S_SCL0, S_SCL0},
    '{S_OUT, S_SCL0, S_SDA0, S_DLY, S_SCL1, S_DLY, S_SCL0,
      S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0,
      S_SCL0, S_SCL0, S_SCL0, S_SCL0},
    '{S_OUT, S_SCL0, S_SDA1, S_DLY, S_SCL1, S_DLY, S_SCL0, S_SDA0,
      S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0, S_SCL0,
      S_SCL0, S_SCL0, S_SCL0},
    '{S_OUT, S_SCL0, S_SDA1, S_DLY, S_IN, S_DLY, S_SCL1, S_POLL, S_PDLY,
      S_OUT, S_SCL0, S_SDA0, S_SCL1, S_DLY, S_DLY, S_SDA1, S_DLY, S_SCL0,
      S_SCL0, S_OUT}
  };

  function automatic logic [PHASE_W-1:0] prog_len(input logic [2:0] op);
    logic [PHASE_W-1:0] len;
    unique case (op_t'(op))
      OP_START:    len = 5'd9;
      OP_STOP:     len = 5'd9;
      OP_WRITE:    len = 5'd10;
      OP_READ:     len = 5'd8;
      OP_ACK:      len = 5'd7;
      OP_NACK:     len = 5'd8;
      OP_WAIT_ACK: len = 5'd20;
      default:     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic step_t prog_step(input logic [2:0] op, input logic [PHASE_W-1:0] ph);
    step_t s;
    s = S_SCL0;
    if (op != OP_NONE && ph < PHASE_W'(PROG_MAX)) begin
      s = PROG[op][ph];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/i2cms_cfg.sv]
// APB register block holding the tick rate and acknowledge timeout settings.
`default_nettype none

module i2cms_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output i2cms_pkg::cfg_t         cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Only bit 2 of the address selects a register; the low bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_us <= i2cms_pkg::TICKS_RESET;
      cfg.ack_timeout  <= i2cms_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == i2cms_pkg::ADDR_TIMEOUT[2]) begin
        cfg.ack_timeout <= pwdata[7:0];
      end else begin
        cfg.ticks_per_us <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == i2cms_pkg::ADDR_TIMEOUT[2]) begin
      prdata = {24'd0, cfg.ack_timeout};
    end else begin
      prdata = {24'd0, cfg.ticks_per_us};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2cms_step.sv]
// Combinational single-tick step of the pin sequencer: next state and result.
`default_nettype none

module i2cms_step (
  input  i2cms_pkg::seq_state_t st,
  input  i2cms_pkg::cfg_t       cfg,
  input  wire logic             cmd_valid,
  input  wire logic [2:0]       operation,
  input  wire logic [7:0]       write_data,
  input  wire logic             sda_in,
  output i2cms_pkg::seq_state_t st_next,
  output i2cms_pkg::result_t    res
);

  logic [7:0] tpu;
  logic       elapsed;
  logic [5:0] nxt;
  logic [4:0] len;
  logic       done;

  assign tpu = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;

  always_comb begin
    st_next = st;
    done    = 1'b0;
    nxt     = 6'd0;
    len     = 5'd0;

    if (st.phase == i2cms_pkg::PHASE_IDLE && cmd_valid && operation != i2cms_pkg::OP_NONE) begin
      st_next.active_op   = operation;
      st_next.phase       = 5'd0;
      st_next.bit_count   = 3'd0;
      st_next.delay_count = 8'd0;
      st_next.poll_count  = 8'd0;
      st_next.shift_reg   = (operation == i2cms_pkg::OP_WRITE) ? write_data : 8'd0;
      if (operation == i2cms_pkg::OP_WAIT_ACK) begin
        st_next.timeout_flag = 1'b0;
      end
    end

    // A delay unit ends on the tick whose count reaches ticks_per_us.
    elapsed = ({1'b0, st_next.delay_count} + 9'd1) >= {1'b0, tpu};

    if (st_next.phase != i2cms_pkg::PHASE_IDLE) begin
      len = i2cms_pkg::prog_len(st_next.active_op);
      nxt = {1'b0, st_next.phase} + 6'd1;
      if (st_next.phase < len) begin
        case (i2cms_pkg::prog_step(st_next.active_op, st_next.phase))
          i2cms_pkg::S_SCL0: st_next.scl_level  = 1'b0;
          i2cms_pkg::S_SCL1: st_next.scl_level  = 1'b1;
          i2cms_pkg::S_SDA0: st_next.sda_level  = 1'b0;
          i2cms_pkg::S_SDA1: st_next.sda_level  = 1'b1;
          i2cms_pkg::S_OUT:  st_next.sda_enable = 1'b1;
          i2cms_pkg::S_IN:   st_next.sda_enable = 1'b0;
          i2cms_pkg::S_DLY: begin
            if (elapsed) begin
              st_next.delay_count = 8'd0;
            end else begin
              st_next.delay_count = st_next.delay_count + 8'd1;
              nxt = {1'b0, st_next.phase};
            end
          end
          i2cms_pkg::S_BIT: begin
            st_next.sda_level = st_next.shift_reg[7];
            st_next.shift_reg = {st_next.shift_reg[6:0], 1'b0};
          end
          i2cms_pkg::S_SCL1S: begin
            st_next.scl_level = 1'b1;
            st_next.shift_reg = {st_next.shift_reg[6:0], sda_in};
          end
          i2cms_pkg::S_DLOOP: begin
            if (!elapsed) begin
              st_next.delay_count = st_next.delay_count + 8'd1;
              nxt = {1'b0, st_next.phase};
            end else begin
              st_next.delay_count = 8'd0;
              if (st_next.bit_count != 3'd7) begin
                st_next.bit_count = st_next.bit_count + 3'd1;
                nxt = {1'b0, i2cms_pkg::LOOP_BODY};
              end
            end
          end
          i2cms_pkg::S_POLL: begin
            if (!sda_in) begin
              nxt = {1'b0, i2cms_pkg::ACK_TAIL};
            end
          end
          i2cms_pkg::S_PDLY: begin
            if (!elapsed) begin
              st_next.delay_count = st_next.delay_count + 8'd1;
              nxt = {1'b0, st_next.phase};
            end else begin
              st_next.delay_count = 8'd0;
              st_next.poll_count  = st_next.poll_count + 8'd1;
              if (({1'b0, st.poll_count} + 9'd1) >= {1'b0, cfg.ack_timeout}) begin
                st_next.timeout_flag = 1'b1;
                nxt = {1'b0, i2cms_pkg::STOP_ENTRY};
              end else begin
                nxt = {1'b0, st_next.phase} - 6'd1;
              end
            end
          end
          default: ;
        endcase
      end
      if (nxt >= {1'b0, len}) begin
        st_next.phase = i2cms_pkg::PHASE_IDLE;
        done = 1'b1;
        if (st_next.active_op == i2cms_pkg::OP_READ) begin
          st_next.last_read = st_next.shift_reg;
        end
      end else begin
        st_next.phase = nxt[4:0];
      end
    end
  end

  always_comb begin
    res.scl         = st_next.scl_level;
    res.sda_out     = st_next.sda_level;
    res.sda_drive   = st_next.sda_enable;
    res.busy_res    = (st_next.phase != i2cms_pkg::PHASE_IDLE);
    res.done_res    = done;
    res.read_data   = st_next.last_read;
    res.ack_missing = st_next.timeout_flag;
  end

endmodule

`default_nettype wire

[hw/rtl/i2c_master_byte_sequencer.sv]
// Top level of the I2C master pin sequencer: stream ports, state and result registers.
// The result beat for an input beat is registered and appears in the cycle after the beat is accepted.
// Throughput: one input beat per cycle; input is taken whenever the result register is
// empty or its beat is taken in the same cycle, so the result register is the only stall.
// Reset (rst, synchronous, active high) idles the sequencer with SCL and SDA high and SDA
// driven, clears the result valid flag and restores the register defaults (1 tick, 20 units).
`default_nettype none

module i2c_master_byte_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] write_data, [8] sda_in, [15:9] zero
  input  wire logic [3:0]  s_tuser,   // [0] cmd_valid, [3:1] operation
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res,
                                      // [4] done_res, [12:5] read_data, [13] ack_missing
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  i2cms_pkg::cfg_t       cfg;
  i2cms_pkg::seq_state_t st;
  i2cms_pkg::seq_state_t st_next;
  i2cms_pkg::result_t    res;
  logic                  in_beat;

  i2cms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Every input beat is one timebase tick; the step logic computes the whole
  // tick from the current state, and the result lands in the output register.
  i2cms_step u_step (
    .st         (st),
    .cfg        (cfg),
    .cmd_valid  (s_tuser[0]),
    .operation  (s_tuser[3:1]),
    .write_data (s_tdata[7:0]),
    .sda_in     (s_tdata[8]),
    .st_next    (st_next),
    .res        (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  // The sequencer state moves only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= i2cms_pkg::STATE_RESET;
    end else if (in_beat) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The payload register needs no reset; it is only read while m_tvalid is high.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= {2'b00, res.ack_missing, res.read_data, res.done_res, res.busy_res,
                  res.sda_drive, res.sda_out, res.scl};
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_in_program: assert property (@(posedge clk) disable iff (rst)
    st.phase != i2cms_pkg::PHASE_IDLE |-> st.phase < i2cms_pkg::prog_len(st.active_op))
    else $error("sequencer phase beyond the program of the active command");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[4] && m_tdata[3]))
    else $error("result reports done and busy together");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> m_tvalid)
    else $error("accepted tick produced no result beat");

  a_busy_tracks_state: assert property (@(posedge clk) disable iff (rst)
    $past(in_beat) && !$past(rst) |-> m_tdata[3] == (st.phase != i2cms_pkg::PHASE_IDLE))
    else $error("busy flag disagrees with the sequencer state");
`endif

endmodule

`default_nettype wire
